[rtl/core/ppt_pkg.sv]
// Shared widths, register indexes, reset values and the divider stage record
// for the projective point transform. No dependencies.
`default_nettype none

package ppt_pkg;

   localparam int PT_W     = 16;                  // Q12.4 coordinate
   localparam int COEF_W   = 16;                  // Q4.12 coefficient
   localparam int ROW_W    = 3 * COEF_W;          // packed row register
   localparam int PROD_W   = PT_W + COEF_W;       // full product
   localparam int CST_W    = COEF_W + 4;          // constant term in product units
   localparam int SUM_W    = 34;                  // row sum, product units
   localparam int NUM_W    = SUM_W + 4;           // numerator scaled by 16
   localparam int DEN_W    = SUM_W;               // divisor magnitude
   localparam int QUO_W    = PT_W + 1;            // quotient magnitude bits
   localparam int CMP_W    = DEN_W + QUO_W - 1;   // widest shifted divisor
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2 = 2'd2;

   localparam logic [ROW_W-1:0] ROW0_RESET = 48'h0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW1_RESET = 48'h0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW2_RESET = 48'h1000_0000_0000;

   // 1.0 in product units (2^-16)
   localparam logic signed [SUM_W-1:0] W_ONE = 34'sd65536;

   localparam logic [PT_W-1:0]  SAT_POS  = 16'h7FFF;
   localparam logic [PT_W-1:0]  SAT_NEG  = 16'h8000;
   localparam logic [QUO_W-1:0] QMAX_POS = 17'd32767;
   localparam logic [QUO_W-1:0] QMAX_NEG = 17'd32768;

   typedef struct packed {
      logic [NUM_W-1:0] rem_x;
      logic [NUM_W-1:0] rem_y;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] q_x;
      logic [QUO_W-1:0] q_y;
      logic             neg_x;
      logic             neg_y;
      logic             ovf_x;
      logic             ovf_y;
      logic             degen;
   } div_stage_type;

endpackage

`default_nettype wire

[rtl/core/projective_point_transform_2d.sv]
// Projective 2D point transform: 3x3 matrix, perspective divide, saturation.
// One transaction per cycle while no stalled response holds the pipe.
// Most of the pipeline is a 17-step restoring divider, one quotient bit per stage.
// A stalled response freezes every stage together; nothing is lost or repeated.
// Reset (sync, active high) empties the pipeline and loads the identity-like rows.
// Depends on ppt_pkg.
`default_nettype none

module projective_point_transform_2d
   import ppt_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   // request channel
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  signed [PT_W-1:0]      req_point_x,
   input  wire  signed [PT_W-1:0]      req_point_y,
   // response channel
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic signed [PT_W-1:0]      rsp_result_x,
   output logic signed [PT_W-1:0]      rsp_result_y,
   output logic                        rsp_saturated,
   output logic                        rsp_w_degenerate,
   // register write channel
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [CSR_IDX_W-1:0]        csr_index,
   input  wire  [ROW_W-1:0]            csr_data
);

   // stage map: 0 input, 1 products, 2 sums, 3..3+DIV_STEPS divider, last output
   localparam int DIV_STEPS = QUO_W;
   localparam int NSTG      = DIV_STEPS + 5;
   localparam int DIV_BASE  = 3;

   // ---------------------------------------------------------------------------
   // Matrix rows. The user must write them only while the pipe is idle, so the
   // product stage can read them directly; the block itself does not enforce it.
   // ---------------------------------------------------------------------------
   logic [ROW_W-1:0] row0_ff, row1_ff, row2_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= ROW0_RESET;
         row1_ff <= ROW1_RESET;
         row2_ff <= ROW2_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW0: row0_ff <= csr_data;
            CSR_ROW1: row1_ff <= csr_data;
            CSR_ROW2: row2_ff <= csr_data;
            default:  ;   // unused index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Flow control: whole pipe advances unless the output holds a stalled
   // transaction.
   // ---------------------------------------------------------------------------
   logic            adv;
   logic [NSTG-1:0] vld_ff;

   assign adv       = !vld_ff[NSTG-1] || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 0: capture the point
   // ---------------------------------------------------------------------------
   logic signed [PT_W-1:0] x_ff, y_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= req_point_x;
         y_ff <= req_point_y;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: six products and the three constant terms (coef * 16)
   // ---------------------------------------------------------------------------
   logic signed [COEF_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   logic signed [PROD_W-1:0] prod_in [0:5];
   logic signed [PROD_W-1:0] prod_ff [0:5];
   logic signed [CST_W-1:0]  cst_in  [0:2];
   logic signed [CST_W-1:0]  cst_ff  [0:2];

   assign m00 = row0_ff[47:32];
   assign m01 = row0_ff[31:16];
   assign m02 = row0_ff[15:0];
   assign m10 = row1_ff[47:32];
   assign m11 = row1_ff[31:16];
   assign m12 = row1_ff[15:0];
   assign m20 = row2_ff[47:32];
   assign m21 = row2_ff[31:16];
   assign m22 = row2_ff[15:0];

   always_comb begin
      prod_in[0] = m00 * x_ff;
      prod_in[1] = m01 * y_ff;
      prod_in[2] = m10 * x_ff;
      prod_in[3] = m11 * y_ff;
      prod_in[4] = m20 * x_ff;
      prod_in[5] = m21 * y_ff;
      cst_in[0]  = {m02, 4'b0000};
      cst_in[1]  = {m12, 4'b0000};
      cst_in[2]  = {m22, 4'b0000};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         cst_ff  <= cst_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: row sums, exact in 2^-16 units
   // ---------------------------------------------------------------------------
   logic signed [SUM_W-1:0] nx_in, ny_in, w_in;
   logic signed [SUM_W-1:0] nx_ff, ny_ff, w_ff;

   assign nx_in = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(cst_ff[0]);
   assign ny_in = SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]) + SUM_W'(cst_ff[1]);
   assign w_in  = SUM_W'(prod_ff[4]) + SUM_W'(prod_ff[5]) + SUM_W'(cst_ff[2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         w_ff  <= w_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: sign/magnitude split, zero-w substitution, overflow pre-check.
   // Quotient fits in QUO_W bits only if |N| < |D| * 2^QUO_W.
   // ---------------------------------------------------------------------------
   logic signed [NUM_W-1:0] nx16, ny16;
   logic signed [SUM_W-1:0] wd;
   logic [NUM_W-1:0]        abs_nx, abs_ny;
   logic [DEN_W-1:0]        abs_d;
   logic                    w_zero;
   div_stage_type           prep_in;
   div_stage_type           div_ff [0:DIV_STEPS];
   div_stage_type           div_in [1:DIV_STEPS];

   always_comb begin
      nx16   = {nx_ff, 4'b0000};
      ny16   = {ny_ff, 4'b0000};
      w_zero = (w_ff == '0);
      wd     = w_zero ? W_ONE : w_ff;
      abs_nx = nx16[NUM_W-1] ? NUM_W'(-nx16) : NUM_W'(nx16);
      abs_ny = ny16[NUM_W-1] ? NUM_W'(-ny16) : NUM_W'(ny16);
      abs_d  = wd[SUM_W-1] ? DEN_W'(-wd) : DEN_W'(wd);

      prep_in.rem_x = abs_nx;
      prep_in.rem_y = abs_ny;
      prep_in.den   = abs_d;
      prep_in.q_x   = '0;
      prep_in.q_y   = '0;
      prep_in.neg_x = nx16[NUM_W-1] ^ wd[SUM_W-1];
      prep_in.neg_y = ny16[NUM_W-1] ^ wd[SUM_W-1];
      prep_in.ovf_x = (abs_nx >> QUO_W) >= NUM_W'(abs_d);
      prep_in.ovf_y = (abs_ny >> QUO_W) >= NUM_W'(abs_d);
      prep_in.degen = w_zero;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= prep_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Restoring divider, one quotient bit per stage, MSB first.
   // Without overflow, the remainder stays below den << (k+1) going into step k.
   // ---------------------------------------------------------------------------
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int K = DIV_STEPS - 1 - j;

      logic [CMP_W-1:0] dsh;
      logic [CMP_W-1:0] rx_ext, ry_ext;
      logic             bit_x, bit_y;

      always_comb begin
         dsh    = CMP_W'(div_ff[j].den) << K;
         rx_ext = CMP_W'(div_ff[j].rem_x);
         ry_ext = CMP_W'(div_ff[j].rem_y);
         bit_x  = (rx_ext >= dsh);
         bit_y  = (ry_ext >= dsh);

         div_in[j+1]       = div_ff[j];
         div_in[j+1].rem_x = bit_x ? NUM_W'(rx_ext - dsh) : div_ff[j].rem_x;
         div_in[j+1].rem_y = bit_y ? NUM_W'(ry_ext - dsh) : div_ff[j].rem_y;
         div_in[j+1].q_x   = {div_ff[j].q_x[QUO_W-2:0], bit_x};
         div_in[j+1].q_y   = {div_ff[j].q_y[QUO_W-2:0], bit_y};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[j+1] <= div_in[j+1];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Output stage: reapply sign and clamp to Q12.4
   // ---------------------------------------------------------------------------
   function automatic logic [PT_W:0] clamp_q(input logic             neg,
                                             input logic             ovf,
                                             input logic [QUO_W-1:0] q);
      logic [PT_W:0] r;
      if (neg) begin
         if (ovf || q > QMAX_NEG) r = {1'b1, SAT_NEG};
         else                     r = {1'b0, PT_W'(-q)};
      end else begin
         if (ovf || q > QMAX_POS) r = {1'b1, SAT_POS};
         else                     r = {1'b0, PT_W'(q)};
      end
      return r;
   endfunction

   logic [PT_W:0]    cx, cy;
   logic [PT_W-1:0]  rx_ff, ry_ff;
   logic             sat_ff, degen_ff;

   assign cx = clamp_q(div_ff[DIV_STEPS].neg_x, div_ff[DIV_STEPS].ovf_x,
                       div_ff[DIV_STEPS].q_x);
   assign cy = clamp_q(div_ff[DIV_STEPS].neg_y, div_ff[DIV_STEPS].ovf_y,
                       div_ff[DIV_STEPS].q_y);

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff    <= cx[PT_W-1:0];
         ry_ff    <= cy[PT_W-1:0];
         sat_ff   <= cx[PT_W] | cy[PT_W];
         degen_ff <= div_ff[DIV_STEPS].degen;
      end
   end

   assign rsp_valid        = vld_ff[NSTG-1];
   assign rsp_result_x     = rx_ff;
   assign rsp_result_y     = ry_ff;
   assign rsp_saturated    = sat_ff;
   assign rsp_w_degenerate = degen_ff;

   // stage indexes are fixed by the layout above
   if (DIV_BASE + DIV_STEPS + 2 != NSTG) begin : g_layout_bad
      $error("stage layout mismatch");
   end

endmodule

`default_nettype wire

[dv/tb_projective_point_transform_2d.sv]
// Self-checking testbench for projective_point_transform_2d: 3x3 matrix, divide by w, saturation.
// Depends on ppt_pkg and the block's RTL; a cycle-free predictor supplies expected responses.
`timescale 1ns / 1ps

module tb_projective_point_transform_2d
   import ppt_pkg::*;
();

   // Coordinate bounds in Q12.4, as wide integers for the predictor.
   localparam longint Q_MAX = 32767;
   localparam longint Q_MIN = -32768;
   // Index 3 decodes to no register; writes there must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   // Cycles with no transaction on any port before the run is declared hung.
   localparam int QUIET_LIMIT = 4000;
   // Settling time once nothing is expected: pipeline depth plus margin.
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic signed [PT_W-1:0] result_x;
      logic signed [PT_W-1:0] result_y;
      logic                   saturated;
      logic                   w_degenerate;
   } projection_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [PT_W-1:0] req_point_x = '0;
   logic signed [PT_W-1:0] req_point_y = '0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic signed [PT_W-1:0] rsp_result_x;
   logic signed [PT_W-1:0] rsp_result_y;
   logic                   rsp_saturated;
   logic                   rsp_w_degenerate;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_ROW0;
   logic [ROW_W-1:0]       csr_data = '0;

   // Predictor's copy of the matrix rows, tracking every accepted register write.
   logic [ROW_W-1:0] matrix_rows [3] = '{ROW0_RESET, ROW1_RESET, ROW2_RESET};
   // Projections still owed by the block, oldest first.
   projection_type projected_q [$];

   int fail_count = 0;
   int quiet_cycles = 0;
   // When set, neither side inserts bubbles or stalls.
   bit steady = 1'b0;

   projective_point_transform_2d uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_x     (rsp_result_x),
      .rsp_result_y     (rsp_result_y),
      .rsp_saturated    (rsp_saturated),
      .rsp_w_degenerate (rsp_w_degenerate),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // One matrix row dotted with (x, y, 1), in 2^-16 units. The constant term
   // is Q4.12, so it is scaled by 16 to line up with the Q4.12 x Q12.4 products.
   function automatic longint row_dot(input logic [ROW_W-1:0] row, input longint px,
                                      input longint py);
      longint c_x, c_y, c_k;
      c_x = $signed(row[ROW_W-1 -: COEF_W]);
      c_y = $signed(row[2*COEF_W-1 -: COEF_W]);
      c_k = $signed(row[COEF_W-1:0]);
      return c_x * px + c_y * py + c_k * 16;
   endfunction

   function automatic logic signed [PT_W-1:0] clamp_q12_4(input longint v);
      if (v > Q_MAX) return PT_W'(Q_MAX);
      if (v < Q_MIN) return PT_W'(Q_MIN);
      return PT_W'(v);
   endfunction

   function automatic projection_type project_point(input logic signed [PT_W-1:0] px,
                                                    input logic signed [PT_W-1:0] py);
      longint         x, y, nx, ny, w, qx, qy;
      projection_type p;
      x  = px;
      y  = py;
      nx = row_dot(matrix_rows[0], x, y);
      ny = row_dot(matrix_rows[1], x, y);
      w  = row_dot(matrix_rows[2], x, y);
      // Only an exact zero is degenerate; it is swapped for 1.0.
      p.w_degenerate = (w == 0);
      if (w == 0) w = W_ONE;
      // SV integer division truncates toward zero, matching the divider.
      qx = (nx * 16) / w;
      qy = (ny * 16) / w;
      p.saturated = (qx > Q_MAX) || (qx < Q_MIN) || (qy > Q_MAX) || (qy < Q_MIN);
      p.result_x  = clamp_q12_4(qx);
      p.result_y  = clamp_q12_4(qy);
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random back-pressure and checking
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 13);
   end

   always @(posedge clock) begin
      projection_type exp_p;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (projected_q.size() == 0) begin
            $error("response transaction with nothing outstanding: x=%0d y=%0d",
                   rsp_result_x, rsp_result_y);
            fail_count++;
         end else begin
            exp_p = projected_q.pop_front();
            if (rsp_result_x !== exp_p.result_x) begin
               $error("result_x: expected %0d, got %0d", exp_p.result_x, rsp_result_x);
               fail_count++;
            end
            if (rsp_result_y !== exp_p.result_y) begin
               $error("result_y: expected %0d, got %0d", exp_p.result_y, rsp_result_y);
               fail_count++;
            end
            if (rsp_saturated !== exp_p.saturated) begin
               $error("saturated: expected %0b, got %0b", exp_p.saturated, rsp_saturated);
               fail_count++;
            end
            if (rsp_w_degenerate !== exp_p.w_degenerate) begin
               $error("w_degenerate: expected %0b, got %0b", exp_p.w_degenerate,
                      rsp_w_degenerate);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: any transaction on any port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("projective_point_transform_2d test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side and register writes
   // ---------------------------------------------------------------------

   // One request transaction. Valid is only dropped for a bubble, never
   // between back-to-back points, and the payload holds while stalled.
   task automatic send_point(input logic signed [PT_W-1:0] px,
                             input logic signed [PT_W-1:0] py);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      projected_q.push_back(project_point(px, py));
   endtask

   // Stop requests and let every outstanding response come back.
   task automatic await_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (projected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Registers only change with the pipeline empty.
   task automatic write_row(input logic [CSR_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
      await_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx != CSR_UNUSED) matrix_rows[idx] = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_matrix(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                              input logic [ROW_W-1:0] r2);
      write_row(CSR_ROW0, r0);
      write_row(CSR_ROW1, r1);
      write_row(CSR_ROW2, r2);
   endtask

   // Coordinate extremes, the origin and a couple of near-zero points.
   task automatic send_corners();
      send_point(16'sh7FFF, -16'sh8000);
      send_point(-16'sh8000, 16'sh7FFF);
      send_point(16'sh0000, 16'sh0000);
      send_point(16'sh0010, -16'sh0010);
      send_point(-16'sh0001, 16'sh0001);
   endtask

   // Coefficient spread around a centre value, e.g. near 1.0 = 4096.
   function automatic logic [COEF_W-1:0] jitter(input int centre, input int span);
      return COEF_W'(centre + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // Coordinate: full range most of the time, small magnitudes otherwise.
   function automatic logic signed [PT_W-1:0] random_coord();
      if ($urandom_range(0, 3) == 0) return PT_W'(int'($urandom_range(0, 511)) - 256);
      return PT_W'($urandom);
   endfunction

   function automatic logic [ROW_W-1:0] random_row();
      return {COEF_W'($urandom), 32'($urandom)};
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset rows: w = x, so the origin is degenerate and small x blows up.
   task automatic test_reset_matrix();
      send_corners();
   endtask

   // Identity: w is exactly 1.0, results equal the inputs.
   task automatic test_identity();
      load_matrix({16'h1000, 32'h0}, {16'h0, 16'h1000, 16'h0}, {32'h0, 16'h1000});
      send_corners();
   endtask

   // All-zero bottom row: every point takes the w = 1.0 substitute.
   task automatic test_zero_w();
      write_row(CSR_ROW2, '0);
      send_corners();
   endtask

   // Smallest nonzero w of either sign: large quotients, saturation.
   task automatic test_tiny_w();
      write_row(CSR_ROW2, {32'h0, 16'h0001});
      send_point(16'sh7FFF, 16'sh0001);
      send_point(-16'sh8000, 16'sh0000);
      write_row(CSR_ROW2, {32'h0, 16'hFFFF});
      send_point(16'sh7FFF, -16'sh8000);
      send_point(16'sh0001, 16'sh0001);
   endtask

   // Most negative, most positive and all-ones coefficients; a write to the
   // unused index must leave the matrix alone.
   task automatic test_coefficient_extremes();
      load_matrix(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'hFFFF_FFFF_FFFF);
      write_row(CSR_UNUSED, random_row());
      send_corners();
   endtask

   // Phases of random points under assorted matrices: fully random, near
   // affine, w hunting for zero along x = 0, and w pinned close to zero.
   task automatic test_random_points();
      logic [ROW_W-1:0]       r0, r1, r2;
      logic signed [PT_W-1:0] px, py;
      for (int phase = 0; phase < 11; phase++) begin
         case (phase % 4)
            0: begin
               r0 = random_row();
               r1 = random_row();
               r2 = random_row();
            end
            1: begin
               r0 = {jitter(4096, 2048), jitter(0, 1024), COEF_W'($urandom)};
               r1 = {jitter(0, 1024), jitter(4096, 2048), COEF_W'($urandom)};
               r2 = {jitter(0, 64), jitter(0, 64), jitter(4096, 1024)};
            end
            2: begin
               r0 = random_row();
               r1 = random_row();
               r2 = {COEF_W'($urandom), 32'h0};
            end
            default: begin
               r0 = {jitter(4096, 512), jitter(0, 512), jitter(0, 4096)};
               r1 = {jitter(0, 512), jitter(4096, 512), jitter(0, 4096)};
               r2 = {32'h0, jitter(0, 8)};
            end
         endcase
         load_matrix(r0, r1, r2);
         if (phase % 3 == 0) write_row(CSR_UNUSED, random_row());
         // One phase runs flat out on both sides.
         steady = (phase == 5);
         for (int n = 0; n < 50; n++) begin
            px = random_coord();
            py = random_coord();
            if (phase % 4 == 2 && $urandom_range(0, 3) == 0) px = '0;
            send_point(px, py);
         end
         steady = 1'b0;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_matrix();
      test_identity();
      test_zero_w();
      test_tiny_w();
      test_coefficient_extremes();
      test_random_points();

      await_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && projected_q.size() == 0) begin
         $display("projective_point_transform_2d test passed");
      end else begin
         $display("projective_point_transform_2d test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/ppt_pkg.sv
rtl/core/projective_point_transform_2d.sv
dv/tb_projective_point_transform_2d.sv
